### rtl/motor_driver_packet_framer_unit_assert.svh
// ----------------------------------------------------------------------------
// motor_driver_packet_framer_unit_assert.svh
// Assertion macros shared by the packet framer queue and byte sequencer.
// ----------------------------------------------------------------------------
`ifndef MOTOR_DRIVER_PACKET_FRAMER_UNIT_ASSERT_SVH
`define MOTOR_DRIVER_PACKET_FRAMER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define MDPF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Condition must never be seen outside reset.
`define MDPF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`else

`define MDPF_ASSERT(lbl, clk, rst_n, prop, msg)
`define MDPF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### rtl/mdpf_pkg.sv
// ----------------------------------------------------------------------------
// mdpf_pkg
// Types, constants and helpers of the motor driver packet framer.
// ----------------------------------------------------------------------------
package mdpf_pkg;

    // Request kinds
    typedef enum logic [3:0] {
        REQ_LEFT     = 4'd0,
        REQ_RIGHT    = 4'd1,
        REQ_DRIVE    = 4'd2,
        REQ_TURN     = 4'd3,
        REQ_STOP     = 4'd4,
        REQ_TIMEOUT  = 4'd5,
        REQ_RAMPING  = 4'd6,
        REQ_DEADBAND = 4'd7,
        REQ_RAW      = 4'd8
    } t_req;

    // Packet framing
    localparam logic [7:0] PKT_ADDR     = 8'd128;
    localparam logic [7:0] PKT_SUM_MASK = 8'h7F;

    // Command codes
    localparam logic [7:0] CMD_LEFT_REV  = 8'd0;
    localparam logic [7:0] CMD_LEFT_FWD  = 8'd1;
    localparam logic [7:0] CMD_RIGHT_FWD = 8'd4;
    localparam logic [7:0] CMD_RIGHT_REV = 8'd5;
    localparam logic [7:0] CMD_TIMEOUT   = 8'd14;
    localparam logic [7:0] CMD_RAMPING   = 8'd16;
    localparam logic [7:0] CMD_DEADBAND  = 8'd17;

    // Value limits
    localparam logic signed [15:0] PWR_LIMIT    = 16'sd126;
    localparam logic signed [15:0] TMO_LIMIT_MS = 16'sd12700;
    localparam logic [13:0]        TMO_ROUND    = 14'd99;
    localparam logic [7:0]         RAMP_LIMIT   = 8'd80;
    localparam logic [7:0]         DEADBAND_LIM = 8'd127;

    // ms / 100 as (ms * 5243) >> 19, exact for ms + 99 up to 12799
    localparam int TMO_SHIFT = 19;
    localparam int TMO_X_W   = 14;
    localparam int TMO_P_W   = 27;
    localparam logic [TMO_P_W-1:0] TMO_RECIP = 27'd5243;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One classified request: one or two packets sharing a value byte
    typedef struct packed {
        logic       two_pkt;
        logic [7:0] cmd0;
        logic [7:0] cmd1;
        logic [7:0] val;
    } t_desc;

    // Address byte has no bits below bit 7, so it drops out of the sum
    function automatic logic [7:0] mdpf_checksum(input logic [7:0] cmd,
                                                 input logic [7:0] val);
        logic [7:0] sum;
        sum = PKT_ADDR + cmd + val;
        return sum & PKT_SUM_MASK;
    endfunction

endpackage

### rtl/mdpf_front.sv
// ----------------------------------------------------------------------------
// mdpf_front
// Classifies a request into a packet descriptor: commands and value byte.
// ----------------------------------------------------------------------------
module mdpf_front
    import mdpf_pkg::*;
(
    input  logic               i_valid,
    input  logic               i_full,
    input  logic [3:0]         i_req_type,
    input  logic signed [15:0] i_amount,
    input  logic [7:0]         i_cmd_byte,
    input  logic [7:0]         i_value_byte,
    output logic               o_stall,
    output logic               o_push,
    output t_desc              o_desc
);

    logic               w_neg;
    logic [7:0]         w_mag;
    logic signed [15:0] w_abs;
    logic [TMO_X_W-1:0] w_ms;
    logic [TMO_X_W-1:0] w_x;
    logic [TMO_P_W-1:0] w_prod;
    logic [7:0]         w_tmo;
    logic               w_known;
    logic [7:0]         w_left_cmd;

    assign w_neg = i_amount[15];
    assign w_abs = w_neg ? -i_amount : i_amount;

    // Saturate power to +/-126 and keep the magnitude
    always_comb begin
        if (i_amount > PWR_LIMIT || i_amount < -PWR_LIMIT) begin
            w_mag = PWR_LIMIT[7:0];
        end else begin
            w_mag = w_abs[7:0];
        end
    end

    // Timeout: ceil(clamp(ms, 0, 12700) / 100)
    always_comb begin
        if (w_neg) begin
            w_ms = '0;
        end else if (i_amount > TMO_LIMIT_MS) begin
            w_ms = TMO_LIMIT_MS[TMO_X_W-1:0];
        end else begin
            w_ms = i_amount[TMO_X_W-1:0];
        end
    end

    assign w_x    = w_ms + TMO_ROUND;
    assign w_prod = TMO_P_W'(w_x) * TMO_RECIP;
    assign w_tmo  = {1'b0, w_prod[TMO_SHIFT+6:TMO_SHIFT]};

    assign w_left_cmd = w_neg ? CMD_LEFT_REV : CMD_LEFT_FWD;

    always_comb begin
        w_known        = 1'b1;
        o_desc.two_pkt = 1'b0;
        o_desc.cmd0    = w_left_cmd;
        o_desc.cmd1    = CMD_RIGHT_FWD;
        o_desc.val     = w_mag;
        case (i_req_type)
            REQ_LEFT: begin
                o_desc.cmd0 = w_left_cmd;
            end
            REQ_RIGHT: begin
                o_desc.cmd0 = w_neg ? CMD_RIGHT_REV : CMD_RIGHT_FWD;
            end
            REQ_DRIVE: begin
                o_desc.two_pkt = 1'b1;
                o_desc.cmd1    = w_neg ? CMD_RIGHT_REV : CMD_RIGHT_FWD;
            end
            REQ_TURN: begin
                o_desc.two_pkt = 1'b1;
                o_desc.cmd1    = w_neg ? CMD_RIGHT_FWD : CMD_RIGHT_REV;
            end
            REQ_STOP: begin
                o_desc.two_pkt = 1'b1;
                o_desc.cmd0    = CMD_LEFT_FWD;
                o_desc.cmd1    = CMD_RIGHT_FWD;
                o_desc.val     = '0;
            end
            REQ_TIMEOUT: begin
                o_desc.cmd0 = CMD_TIMEOUT;
                o_desc.val  = w_tmo;
            end
            REQ_RAMPING: begin
                o_desc.cmd0 = CMD_RAMPING;
                o_desc.val  = (i_value_byte < RAMP_LIMIT) ? i_value_byte : RAMP_LIMIT;
            end
            REQ_DEADBAND: begin
                o_desc.cmd0 = CMD_DEADBAND;
                o_desc.val  = (i_value_byte < DEADBAND_LIM) ? i_value_byte : DEADBAND_LIM;
            end
            REQ_RAW: begin
                o_desc.cmd0 = i_cmd_byte;
                o_desc.val  = i_value_byte;
            end
            default: begin
                // drop unknown kinds
                w_known = 1'b0;
            end
        endcase
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full && w_known;

endmodule

### rtl/mdpf_queue.sv
// ----------------------------------------------------------------------------
// mdpf_queue
// Short descriptor queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
`include "motor_driver_packet_framer_unit_assert.svh"

module mdpf_queue
    import mdpf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_desc o_data,
    output logic  o_empty
);

    t_desc                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `MDPF_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `MDPF_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")
    `MDPF_ASSERT(a_ptr_track, i_clk, i_rst_n, (r_wr_ptr - r_rd_ptr) == r_count[QUEUE_PTR_W-1:0], "queue pointers disagree with count")

endmodule

### rtl/mdpf_back.sv
// ----------------------------------------------------------------------------
// mdpf_back
// Walks a descriptor out as address, command, value and checksum bytes.
// ----------------------------------------------------------------------------
`include "motor_driver_packet_framer_unit_assert.svh"

module mdpf_back
    import mdpf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_desc      i_desc,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_last_byte
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_tx;
    logic       r_last;
    logic [2:0] n_idx;
    logic       w_adv;
    logic       w_load;
    logic       w_last;
    logic [7:0] w_cmd;
    logic [7:0] w_byte;

    assign w_adv  = !r_valid || !i_stall;
    assign w_load = w_adv && !i_empty;
    assign w_cmd  = r_idx[2] ? i_desc.cmd1 : i_desc.cmd0;
    assign w_last = (r_idx[1:0] == 2'd3) && (!i_desc.two_pkt || r_idx[2]);
    assign n_idx  = w_last ? 3'd0 : r_idx + 3'd1;

    always_comb begin
        case (r_idx[1:0])
            2'd0:    w_byte = PKT_ADDR;
            2'd1:    w_byte = w_cmd;
            2'd2:    w_byte = i_desc.val;
            default: w_byte = mdpf_checksum(w_cmd, i_desc.val);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_valid <= w_load;
            end
            if (w_load) begin
                r_idx <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tx   <= w_byte;
            r_last <= w_last;
        end
    end

    assign o_pop       = w_load && w_last;
    assign o_valid     = r_valid;
    assign o_tx_byte   = r_tx;
    assign o_last_byte = r_last;

    `MDPF_ASSERT(a_addr_first, i_clk, i_rst_n, (w_load && r_idx[1:0] == 2'd0) |=> (r_tx == PKT_ADDR && !r_last), "packet does not open with address byte")
    `MDPF_ASSERT(a_single_end, i_clk, i_rst_n, (w_load && !i_desc.two_pkt && r_idx == 3'd3) |=> r_last, "single packet not closed after four bytes")
    `MDPF_ASSERT_NEVER(a_idx_range, i_clk, i_rst_n, !i_empty && !i_desc.two_pkt && r_idx[2], "byte counter past a single packet")

endmodule

### rtl/motor_driver_packet_framer_unit.sv
// ----------------------------------------------------------------------------
// motor_driver_packet_framer_unit
// Turns motor requests into 4-byte serial packets with a 7-bit checksum.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake           Payload
// request   in   i_valid / o_stall   i_req_type, i_amount, i_cmd_byte, i_value_byte
// bytes     out  o_valid / i_stall   o_tx_byte, o_last_byte
//
// One byte leaves per cycle while i_stall is low and a request is queued:
// drive, turn and stop send two packets, the other kinds one packet.
// A taken request is written into the queue, then the sequencer loads its bytes into the output register.
// A 2-entry queue holds requests while the sequencer works or is stalled.
// Reset (synchronous) empties the queue and clears the output valid.
// Unknown request kinds are taken and dropped.
// ----------------------------------------------------------------------------
module motor_driver_packet_framer_unit
    import mdpf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_req_type,
    input  logic signed [15:0] i_amount,
    input  logic [7:0]         i_cmd_byte,
    input  logic [7:0]         i_value_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_tx_byte,
    output logic               o_last_byte
);

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_desc w_push_desc;
    t_desc w_head_desc;

    mdpf_front u_front (
        .i_valid      (i_valid),
        .i_full       (w_full),
        .i_req_type   (i_req_type),
        .i_amount     (i_amount),
        .i_cmd_byte   (i_cmd_byte),
        .i_value_byte (i_value_byte),
        .o_stall      (o_stall),
        .o_push       (w_push),
        .o_desc       (w_push_desc)
    );

    mdpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_desc),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head_desc),
        .o_empty (w_empty)
    );

    mdpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc      (w_head_desc),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tx_byte   (o_tx_byte),
        .o_last_byte (o_last_byte)
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for motor_driver_packet_framer_unit: requests are
// framed into address/command/value/checksum packets by a local predictor,
// and every byte leaving the block is compared in order, with random idling
// on both channels, a long output hold-off and back-to-back bursts.
// ----------------------------------------------------------------------------
module tb_top
    import mdpf_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 24;
    localparam int MS_PER_STEP  = 100;
    localparam int RANDOM_ITEMS = 150;

    typedef struct {
        logic [7:0] tx;
        logic       last;
    } t_frame_byte;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_stall;
    logic [3:0]         i_req_type   = '0;
    logic signed [15:0] i_amount     = '0;
    logic [7:0]         i_cmd_byte   = '0;
    logic [7:0]         i_value_byte = '0;
    logic               o_valid;
    logic               i_stall      = 1'b0;
    logic [7:0]         o_tx_byte;
    logic               o_last_byte;

    t_frame_byte pending_bytes[$];
    int          mismatches     = 0;
    int          requests_sent  = 0;
    int          bytes_checked  = 0;
    int          cycle_count    = 0;
    bit          tx_idle_en     = 1'b0;
    bit          rx_idle_en     = 1'b0;
    int          hold_left      = 0;
    int          rx_run         = 0;

    motor_driver_packet_framer_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_amount     (i_amount),
        .i_cmd_byte   (i_cmd_byte),
        .i_value_byte (i_value_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tx_byte    (o_tx_byte),
        .o_last_byte  (o_last_byte)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout with %0d bytes outstanding", $time, pending_bytes.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Packet predictor
    // ------------------------------------------------------------------
    task automatic push_packet(input logic [7:0] cmd, input logic [7:0] val,
                               input logic ends_request);
        t_frame_byte fb;
        logic [7:0]  sum;
        sum = (PKT_ADDR + cmd + val) & PKT_SUM_MASK;
        fb.last = 1'b0;
        fb.tx = PKT_ADDR;
        pending_bytes.push_back(fb);
        fb.tx = cmd;
        pending_bytes.push_back(fb);
        fb.tx = val;
        pending_bytes.push_back(fb);
        fb.tx = sum;
        fb.last = ends_request;
        pending_bytes.push_back(fb);
    endtask

    task automatic frame_request(input logic [3:0] kind, input logic signed [15:0] amt,
                                 input logic [7:0] cmd, input logic [7:0] val);
        int   power;
        int   ms;
        logic rev;
        power = amt;
        rev = (power < 0);
        if (power > int'(PWR_LIMIT))  power = int'(PWR_LIMIT);
        if (power < -int'(PWR_LIMIT)) power = -int'(PWR_LIMIT);
        if (power < 0)                power = -power;
        ms = amt;
        if (ms < 0)                   ms = 0;
        if (ms > int'(TMO_LIMIT_MS))  ms = int'(TMO_LIMIT_MS);
        case (kind)
            REQ_LEFT:
                push_packet(rev ? CMD_LEFT_REV : CMD_LEFT_FWD, power[7:0], 1'b1);
            REQ_RIGHT:
                push_packet(rev ? CMD_RIGHT_REV : CMD_RIGHT_FWD, power[7:0], 1'b1);
            REQ_DRIVE: begin
                push_packet(rev ? CMD_LEFT_REV : CMD_LEFT_FWD, power[7:0], 1'b0);
                push_packet(rev ? CMD_RIGHT_REV : CMD_RIGHT_FWD, power[7:0], 1'b1);
            end
            REQ_TURN: begin
                // right side runs the opposite sense
                push_packet(rev ? CMD_LEFT_REV : CMD_LEFT_FWD, power[7:0], 1'b0);
                push_packet(rev ? CMD_RIGHT_FWD : CMD_RIGHT_REV, power[7:0], 1'b1);
            end
            REQ_STOP: begin
                push_packet(CMD_LEFT_FWD, 8'd0, 1'b0);
                push_packet(CMD_RIGHT_FWD, 8'd0, 1'b1);
            end
            REQ_TIMEOUT:
                push_packet(CMD_TIMEOUT, 8'((ms + int'(TMO_ROUND)) / MS_PER_STEP), 1'b1);
            REQ_RAMPING:
                push_packet(CMD_RAMPING, (val < RAMP_LIMIT) ? val : RAMP_LIMIT, 1'b1);
            REQ_DEADBAND:
                push_packet(CMD_DEADBAND, (val < DEADBAND_LIM) ? val : DEADBAND_LIM, 1'b1);
            REQ_RAW:
                push_packet(cmd, val, 1'b1);
            default: ;  // unknown kinds are dropped by the block
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (!tx_idle_en || r < 5) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic send_request(input logic [3:0] kind, input logic signed [15:0] amt,
                                input logic [7:0] cmd, input logic [7:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid      = 1'b1;
        i_req_type   = kind;
        i_amount     = amt;
        i_cmd_byte   = cmd;
        i_value_byte = val;
        // hold the payload until the transfer happens
        do @(posedge i_clk); while (o_stall);
        frame_request(kind, amt, cmd, val);
        requests_sent++;
    endtask

    task automatic send_random();
        logic [3:0]         kind;
        logic signed [15:0] amt;
        kind = ($urandom_range(0, 19) < 18) ? 4'($urandom_range(0, 8))
                                            : 4'($urandom_range(9, 15));
        case ($urandom_range(0, 3))
            0:       amt = 16'($urandom);
            1:       amt = 16'($urandom_range(0, 300)) - 16'sd150;
            2:       amt = 16'($urandom_range(0, 13000)) - 16'sd100;
            default: amt = $urandom_range(0, 1) ? 16'sh7FFF - 16'($urandom_range(0, 3))
                                                : 16'sh8000 + 16'($urandom_range(0, 3));
        endcase
        send_request(kind, amt, 8'($urandom), 8'($urandom));
    endtask

    task automatic release_request();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Byte side: stall pattern and checker
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else if (!rx_idle_en) begin
            i_stall = 1'b0;
            rx_run  = 0;
        end else if (rx_run > 0) begin
            rx_run--;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    i_stall = 1'b0;
                    rx_run  = $urandom_range(0, 5);
                end
                6, 7, 8: begin
                    i_stall = 1'b1;
                    rx_run  = $urandom_range(0, 2);
                end
                default: begin
                    i_stall = 1'b1;
                    rx_run  = $urandom_range(14, 39);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : byte_check
        t_frame_byte want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t ERROR unexpected byte: expected none, actual %02h last %0b",
                         $time, o_tx_byte, o_last_byte);
                mismatches++;
            end else begin
                want = pending_bytes.pop_front();
                bytes_checked++;
                if (o_tx_byte !== want.tx) begin
                    $display("%0t ERROR tx_byte: expected %02h, actual %02h",
                             $time, want.tx, o_tx_byte);
                    mismatches++;
                end
                if (o_last_byte !== want.last) begin
                    $display("%0t ERROR last_byte: expected %0b, actual %0b",
                             $time, want.last, o_last_byte);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_power_requests();
        send_request(REQ_LEFT,  16'sd126,   8'($urandom), 8'($urandom));
        send_request(REQ_LEFT,  16'sh8000,  8'($urandom), 8'($urandom));
        send_request(REQ_RIGHT, 16'sd32767, 8'($urandom), 8'($urandom));
        send_request(REQ_RIGHT, -16'sd1,    8'($urandom), 8'($urandom));
        send_request(REQ_DRIVE, 16'sd0,     8'($urandom), 8'($urandom));
        send_request(REQ_DRIVE, -16'sd127,  8'($urandom), 8'($urandom));
        send_request(REQ_TURN,  16'sd127,   8'($urandom), 8'($urandom));
        send_request(REQ_TURN,  -16'sd126,  8'($urandom), 8'($urandom));
    endtask

    task automatic test_setting_requests();
        send_request(REQ_STOP,     16'sd99,    8'hFF, 8'hFF);
        send_request(REQ_TIMEOUT,  -16'sd5,    8'h00, 8'h00);
        send_request(REQ_TIMEOUT,  16'sd0,     8'h00, 8'h00);
        send_request(REQ_TIMEOUT,  16'sd1,     8'h00, 8'h00);
        send_request(REQ_TIMEOUT,  16'sd101,   8'h00, 8'h00);
        send_request(REQ_TIMEOUT,  16'sd12700, 8'h00, 8'h00);
        send_request(REQ_TIMEOUT,  16'sd32767, 8'h00, 8'h00);
        send_request(REQ_RAMPING,  16'sd0,     8'h00, 8'd81);
        send_request(REQ_RAMPING,  -16'sd1,    8'hFF, 8'hFF);
        send_request(REQ_DEADBAND, 16'sd0,     8'h00, 8'd127);
        send_request(REQ_DEADBAND, 16'sd0,     8'h00, 8'd128);
        send_request(REQ_RAW,      16'sd0,     8'h00, 8'h00);
        send_request(REQ_RAW,      -16'sd1,    8'hFF, 8'hFF);
        // unknown kinds: taken, nothing comes out
        send_request(4'd9,         16'sd5,     8'h12, 8'h34);
        send_request(4'd15,        -16'sd5,    8'h56, 8'h78);
        send_request(REQ_STOP,     16'sd0,     8'h00, 8'h00);
    endtask

    task automatic test_random_traffic();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (RANDOM_ITEMS) send_random();
        // stretch with no idling on either side
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (15) send_random();
    endtask

    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        hold_left  = 250;
        // keep offering while the output is held, so the queue fills
        repeat (20) send_random();
        release_request();
        wait_drained();
    endtask

    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        repeat (20) send_random();
        release_request();
        wait_drained();
        rx_idle_en = 1'b0;
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_power_requests();
        test_setting_requests();
        release_request();
        wait_drained();
        test_random_traffic();
        release_request();
        wait_drained();
        test_backpressure();
        test_back_to_back();
        release_request();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_bytes.size() != 0) begin
            $display("%0t ERROR %0d expected bytes never arrived", $time, pending_bytes.size());
            mismatches++;
        end
        $display("covered all request kinds, power and timeout limits, unknown kinds,");
        $display("random and long output stalls: %0d requests, %0d bytes, %0d mismatches",
                 requests_sent, bytes_checked, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
